@@ hw/rtl/abe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package abe_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [1:0] MODE_FAST   = 2'd0;
    localparam logic [1:0] MODE_SLOW   = 2'd1;
    localparam logic [1:0] MODE_RTT    = 2'd2;
    localparam logic [1:0] MODE_IGNORE = 2'd3;

    localparam logic [1:0] DEC_UPDATED = 2'd0;
    localparam logic [1:0] DEC_RESYNC  = 2'd1;
    localparam logic [1:0] DEC_SAMPLE  = 2'd2;
    localparam logic [1:0] DEC_INITIAL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MSS        = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RTT_FLOOR  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TIME = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ  = 8'd3;

    localparam logic [15:0] MSS_RST       = 16'd1460;
    localparam logic [15:0] RTT_FLOOR_RST = 16'd50;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        now;
        logic [31:0]        acked_seq;
        logic signed [31:0] rtt_sample;
    } t_in;

    typedef struct packed {
        logic [31:0] bw_estimate;
        logic [31:0] bw_raw_estimate;
        logic [31:0] window_bytes;
        logic [1:0]  decision;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_FILT1,
        S_FILT2,
        S_ACC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_step;
        logic filt1;
        logic filt2;
        logic acc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_ack;
        logic sample;
        logic div_last;
    } t_sts;

endpackage

`default_nettype wire

@@ hw/rtl/abe_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module abe_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire abe_pkg::t_sts i_sts,
    output abe_pkg::t_cmd      o_cmd
);
    import abe_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (!i_sts.is_ack) begin
                    n_state = S_OUT;
                end else if (i_sts.sample) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_ACC;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FILT1;
                end
            end
            S_FILT1: begin
                o_cmd.filt1 = 1'b1;
                n_state     = S_FILT2;
            end
            S_FILT2: begin
                o_cmd.filt2 = 1'b1;
                n_state     = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ hw/rtl/abe_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module abe_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [abe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [abe_pkg::DATA_W-1:0]      i_cfg_data,
    input  wire abe_pkg::t_in                    i_in_data,
    input  wire abe_pkg::t_cmd                   i_cmd,
    output abe_pkg::t_sts                        o_sts,
    output abe_pkg::t_out                        o_out_data
);
    import abe_pkg::*;

    function automatic logic [31:0] avg78(input logic [31:0] old, input logic [31:0] smp);
        logic [34:0] acc;
        acc = {old, 3'b000} - {3'b000, old} + {3'b000, smp};
        return acc[34:3];
    endfunction

    logic [15:0] r_mss;
    logic [15:0] r_rtt_floor;
    logic [31:0] r_bw_raw;
    logic [31:0] r_bw_smooth;
    logic [31:0] r_window_start;
    logic [31:0] r_byte_sum;
    logic [31:0] r_last_seq;
    logic [31:0] r_credited;
    logic [31:0] r_rtt_ticks;
    logic        r_first_pending;
    logic [1:0]  r_decision;
    logic        r_was_empty;

    t_in                  r_item;
    t_out                 r_out;
    logic [31:0]          r_rem;
    logic [31:0]          r_quo;
    logic [31:0]          r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic [31:0] w_elapsed;
    logic [31:0] w_bound;
    logic        w_is_ack;
    logic        w_sample;
    logic        w_rtt_pos;
    logic [32:0] w_trial;
    logic [31:0] w_mss32;
    logic [31:0] w_diff;
    logic [31:0] w_cumul1;
    logic [31:0] w_cred1;
    logic [31:0] w_cumul2;
    logic [31:0] w_cred2;

    assign w_elapsed = r_item.now - r_window_start;
    assign w_bound   = (r_rtt_ticks > {16'd0, r_rtt_floor}) ? r_rtt_ticks
                                                             : {16'd0, r_rtt_floor};
    assign w_is_ack  = (r_item.mode == MODE_FAST) || (r_item.mode == MODE_SLOW);
    assign w_sample  = (r_rtt_ticks != '0) && (w_elapsed > w_bound);
    assign w_rtt_pos = (r_item.rtt_sample != '0) && !r_item.rtt_sample[31];
    assign w_trial   = {r_rem, r_quo[31]} - {1'b0, r_dvs};

    // slow ack: duplicate credit, then take credit back on a large cumulative ack
    assign w_mss32 = {16'd0, r_mss};
    assign w_diff  = r_item.acked_seq - r_last_seq;
    always_comb begin
        w_cumul1 = w_diff;
        w_cred1  = r_credited;
        if (w_diff == '0) begin
            w_cred1  = r_credited + w_mss32;
            w_cumul1 = w_mss32;
        end
        w_cumul2 = w_cumul1;
        w_cred2  = w_cred1;
        if (w_cumul1 > w_mss32) begin
            if (w_cred1 >= w_cumul1) begin
                w_cred2  = w_cred1 - w_cumul1;
                w_cumul2 = w_mss32;
            end else begin
                w_cumul2 = w_cumul1 - w_cred1;
                w_cred2  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mss           <= MSS_RST;
            r_rtt_floor     <= RTT_FLOOR_RST;
            r_bw_raw        <= '0;
            r_bw_smooth     <= '0;
            r_window_start  <= '0;
            r_byte_sum      <= '0;
            r_last_seq      <= '0;
            r_credited      <= '0;
            r_rtt_ticks     <= '0;
            r_first_pending <= 1'b1;
            r_decision      <= DEC_INITIAL;
            r_was_empty     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MSS:        r_mss          <= i_cfg_data[15:0];
                    CFG_RTT_FLOOR:  r_rtt_floor    <= i_cfg_data[15:0];
                    CFG_START_TIME: r_window_start <= i_cfg_data;
                    CFG_START_SEQ:  r_last_seq     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.eval) begin
                case (r_item.mode)
                    MODE_FAST, MODE_SLOW: begin
                        r_decision <= DEC_UPDATED;
                        if (r_first_pending) begin
                            r_last_seq      <= r_item.acked_seq;
                            r_first_pending <= 1'b0;
                            r_decision      <= DEC_RESYNC;
                        end
                    end
                    MODE_RTT: begin
                        if (w_rtt_pos) begin
                            r_rtt_ticks <= r_item.rtt_sample;
                        end
                    end
                    MODE_IGNORE: ;
                    default: ;
                endcase
            end
            if (i_cmd.filt1) begin
                r_was_empty <= (r_bw_raw == '0) && (r_bw_smooth == '0);
                if ((r_bw_raw == '0) && (r_bw_smooth == '0)) begin
                    r_bw_raw    <= r_quo;
                    r_bw_smooth <= r_quo;
                end else begin
                    r_bw_raw <= avg78(r_bw_raw, r_quo);
                end
            end
            if (i_cmd.filt2) begin
                if (!r_was_empty) begin
                    r_bw_smooth <= avg78(r_bw_smooth, r_bw_raw);
                end
                r_byte_sum     <= '0;
                r_window_start <= r_item.now;
                r_decision     <= DEC_SAMPLE;
            end
            if (i_cmd.acc) begin
                r_last_seq <= r_item.acked_seq;
                if (r_item.mode == MODE_SLOW) begin
                    r_byte_sum <= r_byte_sum + w_cumul2;
                    r_credited <= w_cred2;
                end else begin
                    r_byte_sum <= r_byte_sum + w_diff;
                end
            end
        end
    end

    // restoring divider, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.eval) begin
            r_rem <= '0;
            r_quo <= r_byte_sum;
            r_dvs <= w_elapsed;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (!w_trial[32]) begin
                r_rem <= w_trial[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= {r_rem[30:0], r_quo[31]};
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            r_out.bw_estimate     <= r_bw_smooth;
            r_out.bw_raw_estimate <= r_bw_raw;
            r_out.window_bytes    <= r_byte_sum;
            r_out.decision        <= r_decision;
        end
    end

    assign o_sts.is_ack   = w_is_ack;
    assign o_sts.sample   = w_sample;
    assign o_sts.div_last = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    assign o_out_data     = r_out;

endmodule

`default_nettype wire

@@ hw/rtl/ack_bandwidth_estimator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bandwidth estimator for one connection, fed with ack events over a
// valid/ready channel; every event gives one result transfer. Events are
// handled one at a time. After evaluation, an RTT sample or ignored event
// goes straight to the output step, and an ack that closes no window passes
// the accumulate step first; an ack that closes a window also runs the
// restoring divider (byte sum over elapsed ticks) and the two filter steps. A
// finished result sits in an output register, so the next event is taken
// while it waits; that event's own result then holds until the register is
// free. Configuration writes are taken every cycle and belong in idle time.

module ack_bandwidth_estimator_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire abe_pkg::t_in                  i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output abe_pkg::t_out                      o_out_data,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [abe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [abe_pkg::DATA_W-1:0]    i_cfg_data
);
    import abe_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    abe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    abe_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

@@ hw/rtl/abe_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module abe_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_ready,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire abe_pkg::t_out o_out_data
);
    import abe_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second event taken while one is in work");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result appeared without processing");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind ack_bandwidth_estimator_core abe_checker u_abe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

@@ sim/ack_bandwidth_estimator_core_tb.sv @@
`timescale 1ns / 1ps

module ack_bandwidth_estimator_core_tb;

    import abe_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 60;
    localparam int unsigned MAX_IDLE      = 40;

    class bw_tracker;
        logic [15:0] mss;
        logic [15:0] rtt_floor;
        logic [31:0] bw_raw;
        logic [31:0] bw_smooth;
        logic [31:0] window_start;
        logic [31:0] byte_sum;
        logic [31:0] last_seq;
        logic [31:0] credited;
        logic [31:0] rtt_ticks;
        logic        first_pending;
        logic [1:0]  decision;
        t_out        pending_estimates[$];
        int unsigned mismatches;

        function new();
            mss           = MSS_RST;
            rtt_floor     = RTT_FLOOR_RST;
            bw_raw        = '0;
            bw_smooth     = '0;
            window_start  = '0;
            byte_sum      = '0;
            last_seq      = '0;
            credited      = '0;
            rtt_ticks     = '0;
            first_pending = 1'b1;
            decision      = DEC_INITIAL;
            mismatches    = 0;
        endfunction

        function void load_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                CFG_MSS:        mss = value[15:0];
                CFG_RTT_FLOOR:  rtt_floor = value[15:0];
                CFG_START_TIME: window_start = value;
                CFG_START_SEQ:  last_seq = value;
                default: ;
            endcase
        endfunction

        // 7/8 moving average, formed wide
        function logic [31:0] blend_78(logic [31:0] old_val, logic [31:0] fresh);
            logic [39:0] acc;
            acc = {8'd0, old_val} * 40'd7 + {8'd0, fresh};
            return acc[34:3];
        endfunction

        function void close_window(logic [31:0] now, logic [31:0] acked);
            logic [31:0] elapsed;
            logic [31:0] bound;
            logic [31:0] quot;
            elapsed  = now - window_start;
            decision = DEC_UPDATED;
            if (first_pending) begin
                last_seq      = acked;
                first_pending = 1'b0;
                decision      = DEC_RESYNC;
            end
            bound = (rtt_ticks > {16'd0, rtt_floor}) ? rtt_ticks : {16'd0, rtt_floor};
            if (rtt_ticks != 0 && elapsed > bound) begin
                quot = byte_sum / elapsed;
                if (bw_raw == 0 && bw_smooth == 0) begin
                    bw_raw    = quot;
                    bw_smooth = quot;
                end else begin
                    bw_raw    = blend_78(bw_raw, quot);
                    bw_smooth = blend_78(bw_smooth, bw_raw);
                end
                byte_sum     = '0;
                window_start = now;
                decision     = DEC_SAMPLE;
            end
        endfunction

        // duplicate acks earn one segment; delayed acks pay the credit back
        function logic [31:0] slow_bytes(logic [31:0] acked);
            logic [31:0] cumul;
            logic [31:0] seg;
            seg   = {16'd0, mss};
            cumul = acked - last_seq;
            if (cumul == 0) begin
                credited = credited + seg;
                cumul    = seg;
            end
            if (cumul > seg) begin
                if (credited >= cumul) begin
                    credited = credited - cumul;
                    cumul    = seg;
                end else begin
                    cumul    = cumul - credited;
                    credited = '0;
                end
            end
            last_seq = acked;
            return cumul;
        endfunction

        function void accept_event(t_in ev);
            t_out est;
            case (ev.mode)
                MODE_FAST: begin
                    close_window(ev.now, ev.acked_seq);
                    byte_sum = byte_sum + (ev.acked_seq - last_seq);
                    last_seq = ev.acked_seq;
                end
                MODE_SLOW: begin
                    close_window(ev.now, ev.acked_seq);
                    byte_sum = byte_sum + slow_bytes(ev.acked_seq);
                end
                MODE_RTT: begin
                    if (!ev.rtt_sample[31] && ev.rtt_sample != 0) begin
                        rtt_ticks = ev.rtt_sample;
                    end
                end
                default: ;
            endcase
            est.bw_estimate     = bw_smooth;
            est.bw_raw_estimate = bw_raw;
            est.window_bytes    = byte_sum;
            est.decision        = decision;
            pending_estimates.push_back(est);
        endfunction

        function void compare_estimate(t_out got);
            t_out want;
            if (pending_estimates.size() == 0) begin
                $error("result transfer with no event outstanding: %p", got);
                mismatches++;
                return;
            end
            want = pending_estimates.pop_front();
            if (got.bw_estimate !== want.bw_estimate) begin
                $error("bw_estimate: expected %0d, actual %0d",
                       want.bw_estimate, got.bw_estimate);
                mismatches++;
            end
            if (got.bw_raw_estimate !== want.bw_raw_estimate) begin
                $error("bw_raw_estimate: expected %0d, actual %0d",
                       want.bw_raw_estimate, got.bw_raw_estimate);
                mismatches++;
            end
            if (got.window_bytes !== want.window_bytes) begin
                $error("window_bytes: expected %0d, actual %0d",
                       want.window_bytes, got.window_bytes);
                mismatches++;
            end
            if (got.decision !== want.decision) begin
                $error("decision: expected %0d, actual %0d", want.decision, got.decision);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk     = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in                  in_data   = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data  = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    t_out                 o_out_data;
    logic                 o_cfg_ready;

    bw_tracker tracker = new();

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned tick_step      = 40;
    int unsigned rtt_max        = 100;
    logic [31:0] stream_now     = '0;
    logic [31:0] stream_seq     = '0;
    logic [15:0] gen_mss        = MSS_RST;

    ack_bandwidth_estimator_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            tracker.compare_estimate(o_out_data);
        end
        out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    function automatic int unsigned idle_cycles(int unsigned pct);
        int unsigned n = 0;
        while (n < MAX_IDLE && $urandom_range(99, 0) < pct) n++;
        return n;
    endfunction

    // returns on the accepting edge with valid still high
    task automatic send_event(input t_in ev);
        int unsigned gap;
        gap = idle_cycles(send_idle_pct);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.accept_event(ev);
    endtask

    task automatic send_fields(input logic [1:0] mode, input logic [31:0] now,
                               input logic [31:0] acked, input logic [31:0] rtt);
        t_in ev;
        ev.mode       = mode;
        ev.now        = now;
        ev.acked_seq  = acked;
        ev.rtt_sample = rtt;
        send_event(ev);
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        do @(posedge i_clk); while (tracker.pending_estimates.size() != 0);
    endtask

    task automatic cfg_transfer(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.load_register(idx, value);
    endtask

    task automatic program_registers(input logic [15:0] mss, input logic [15:0] floor_ticks,
                                     input logic [31:0] start_time, input logic [31:0] start_seq);
        // unmapped index must be ignored
        cfg_transfer(CFG_IDX_W'($urandom_range(255, 4)), $urandom);
        cfg_transfer(CFG_MSS, {16'($urandom), mss});
        cfg_transfer(CFG_RTT_FLOOR, {16'($urandom), floor_ticks});
        cfg_transfer(CFG_START_TIME, start_time);
        cfg_transfer(CFG_START_SEQ, start_seq);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
        gen_mss    = mss;
        stream_now = start_time;
        stream_seq = start_seq;
    endtask

    function automatic t_in next_event();
        t_in         ev;
        int unsigned pick;
        int unsigned kind;
        logic [31:0] step;
        pick          = $urandom_range(99, 0);
        ev.mode       = 2'($urandom);
        ev.now        = $urandom;
        ev.acked_seq  = $urandom;
        ev.rtt_sample = $urandom;
        if (pick < 8) begin
            return ev;
        end
        if (pick < 20) begin
            ev.mode = MODE_RTT;
            if ($urandom_range(9, 0) != 0) ev.rtt_sample = $urandom_range(rtt_max, 1);
            return ev;
        end
        if (pick < 24) begin
            ev.mode = MODE_IGNORE;
            return ev;
        end
        kind = $urandom_range(9, 0);
        if (kind < 3) begin
            step = '0;
        end else if (kind < 7) begin
            step = 32'(gen_mss) * $urandom_range(3, 1);
        end else if (kind < 9) begin
            step = $urandom_range(gen_mss, 1);
        end else begin
            step = $urandom_range(20 * 32'(gen_mss), 0);
        end
        stream_now   = stream_now + $urandom_range(tick_step, 0);
        stream_seq   = stream_seq + step;
        ev.mode      = $urandom_range(1, 0) ? MODE_SLOW : MODE_FAST;
        ev.now       = stream_now;
        ev.acked_seq = stream_seq;
        return ev;
    endfunction

    task automatic run_phase(input int unsigned count, input int unsigned send_pct,
                             input int unsigned recv_pct, input int unsigned ticks,
                             input int unsigned rtt_top);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        tick_step      = ticks;
        rtt_max        = rtt_top;
        for (int unsigned k = 0; k < count; k++) begin
            if (k == count / 2) begin
                stop_sending();
                wait_for_results();
            end
            send_event(next_event());
        end
        stop_sending();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        send_fields(MODE_RTT, 32'd0, 32'd0, 32'd0);
        send_fields(MODE_IGNORE, '1, '1, '1);
        send_fields(MODE_FAST, 32'd10, 32'd1000, 32'd0);
        send_fields(MODE_FAST, 32'd20, 32'd4000, 32'd0);
        send_fields(MODE_SLOW, 32'd25, 32'd4000, 32'd0);
        send_fields(MODE_SLOW, 32'd30, 32'd4000, 32'd0);
        send_fields(MODE_SLOW, 32'd35, 32'd11300, 32'd0);
        send_fields(MODE_SLOW, 32'd40, 32'd11400, 32'd0);
        send_fields(MODE_RTT, 32'd40, 32'd0, 32'h8000_0000);
        send_fields(MODE_RTT, 32'd40, 32'd0, 32'h7FFF_FFFF);
        send_fields(MODE_FAST, 32'hFFFF_FFFF, 32'd12860, 32'd0);
        send_fields(MODE_RTT, 32'd0, 32'd0, 32'd1);
        send_fields(MODE_FAST, 32'd40, 32'd14320, 32'd0);
        send_fields(MODE_SLOW, 32'd100, 32'd14320, 32'd0);
        send_fields(MODE_FAST, 32'd101, 32'd14000, 32'd0);
        send_fields(MODE_SLOW, 32'd102, 32'd0, 32'd0);
        send_fields(MODE_SLOW, 32'd103, 32'hFFFF_FFFF, 32'd0);
        send_fields(MODE_IGNORE, 32'd0, 32'd0, 32'd0);
        send_fields(MODE_RTT, 32'd103, 32'd0, 32'hFFFF_FFFF);
        send_fields(MODE_FAST, 32'd200, 32'd0, 32'd0);
        send_fields(MODE_FAST, 32'h8000_0000, 32'h8000_0000, 32'd0);
        stop_sending();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        program_registers(16'd1, 16'd1, 32'hFFFF_FF00, 32'hFFFF_FFF0);
        run_phase(260, 0, 0, 8, 16);
        program_registers(16'hFFFF, 16'hFFFF, 32'd0, 32'd0);
        run_phase(260, 83, 0, 30000, 100000);
        program_registers(16'd1460, 16'd50, $urandom, $urandom);
        run_phase(260, 0, 83, 40, 120);
        program_registers(16'($urandom_range(65535, 1)), 16'($urandom_range(500, 1)),
                          $urandom, $urandom);
        run_phase(260, 14, 14, 300, 600);
        program_registers(16'd536, 16'd20, $urandom, $urandom);
        run_phase(260, 0, 0, 30, 60);

        if (tracker.mismatches == 0 && tracker.pending_estimates.size() == 0) begin
            $display("ack_bandwidth_estimator_core regression: pass");
        end else begin
            $display("ack_bandwidth_estimator_core regression: fail");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("ack_bandwidth_estimator_core regression: fail");
        $finish;
    end

endmodule
